// File: hdl/tvc_pkg.sv
package tvc_pkg;

   localparam int unsigned WORD_W = 64;
   localparam int unsigned TEXT_BYTES_MAX = 7;
   localparam logic [2:0] INLINE_TEXT_BYTES = 3'd7;

   localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;
   localparam logic [10:0] EXP_START = 11'h200;
   localparam logic [51:0] ZERO_MANT = 52'h0_FFFF_FFFF_FFFF;
   localparam logic [63:0] INT_BIAS = 64'h1FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] INT_LIMIT = 64'h3FFF_FFFF_FFFF_FFFD;

   localparam logic [7:0] BOOL_TRUE_WORD = 8'hFF;
   localparam logic [7:0] BOOL_FALSE_WORD = 8'h8F;
   localparam logic [63:0] NONE_WORD = 64'hB;
   localparam logic [7:0] TAG_MASK = 8'h8F;
   localparam logic [7:0] TAG_SHORT_STR = 8'h0F;
   localparam logic [7:0] TAG_BOOL = 8'h8F;
   localparam logic [3:0] TAG_LONG_STR = 4'h3;
   localparam logic [3:0] TAG_ARRAY = 4'h7;

   typedef enum logic [2:0] {
      FUNC_ENC_BOOL   = 3'd0,
      FUNC_ENC_INT    = 3'd1,
      FUNC_ENC_DOUBLE = 3'd2,
      FUNC_ENC_STRING = 3'd3,
      FUNC_DECODE     = 3'd4
   } func_type;

   typedef enum logic [3:0] {
      KIND_NUM       = 4'd0,
      KIND_INT       = 4'd1,
      KIND_NONE      = 4'd2,
      KIND_BOOL      = 4'd3,
      KIND_SHORT_STR = 4'd4,
      KIND_LONG_STR  = 4'd5,
      KIND_ARRAY     = 4'd6,
      KIND_OBJECT    = 4'd7,
      KIND_INVALID   = 4'd8
   } kind_type;

   typedef struct packed {
      logic [63:0] boxed_out;
      logic [3:0]  kind;
      logic [63:0] value_out;
      logic [2:0]  length_out;
      logic        needs_heap;
   } result_type;

   function automatic logic [55:0] byte_mask(input logic [2:0] len);
      logic [55:0] mask;
      mask = '0;
      for (int i = 0; i < TEXT_BYTES_MAX; i++) begin
         if (3'(i) < len) begin
            mask[i*8 +: 8] = 8'hFF;
         end
      end
      return mask;
   endfunction

endpackage

// File: hdl/tvc_encode.sv
module tvc_encode (
   input  logic [2:0]          func,
   input  logic [63:0]         value_bits,
   input  logic [2:0]          text_length,
   output tvc_pkg::result_type result
);
   import tvc_pkg::*;

   logic [63:0] int_off;
   logic        int_ok;
   logic        num_zero;
   logic        num_fits;
   logic        num_above;
   logic        num_spec;
   logic        num_ok;
   logic [63:0] num_bits;
   logic        text_ok;
   logic [55:0] text_bytes;
   logic [63:0] boxed;
   logic        ok;

   assign int_off = value_bits + INT_BIAS;
   assign int_ok = (int_off <= INT_LIMIT);

   assign num_zero = (value_bits[62:0] == '0);
   assign num_fits = value_bits[61] ^ value_bits[62];
   assign num_above = (value_bits[62:52] != EXP_START);
   assign num_spec = (value_bits[62:52] == EXP_ALL_ONES);
   assign num_ok = num_zero || (num_fits && num_above) || num_spec;

   always_comb begin
      num_bits = value_bits;
      if (num_zero) begin
         num_bits = {value_bits[63], EXP_START, ZERO_MANT};
      end else if (num_spec) begin
         num_bits = {value_bits[63], EXP_START, value_bits[51:0]};
      end
   end

   assign text_ok = (text_length <= INLINE_TEXT_BYTES);
   assign text_bytes = value_bits[55:0] & byte_mask(text_length);

   always_comb begin
      boxed = '0;
      ok = 1'b1;
      case (func)
         FUNC_ENC_BOOL: begin
            boxed = {56'd0, value_bits[0] ? BOOL_TRUE_WORD : BOOL_FALSE_WORD};
         end
         FUNC_ENC_INT: begin
            ok = int_ok;
            boxed = {value_bits[60:0], value_bits[63], 2'b01};
         end
         FUNC_ENC_DOUBLE: begin
            ok = num_ok;
            boxed = {num_bits[60:0], num_bits[63], num_bits[62], 1'b0};
         end
         FUNC_ENC_STRING: begin
            ok = text_ok;
            boxed = {text_bytes, 1'b0, text_length, 4'hF};
         end
         default: begin
            boxed = '0;
         end
      endcase
   end

   always_comb begin
      result = '0;
      result.boxed_out = ok ? boxed : '0;
      result.kind = KIND_INVALID;
      result.needs_heap = ~ok;
   end

endmodule

// File: hdl/tvc_decode.sv
module tvc_decode (
   input  logic [63:0]         boxed_word,
   output tvc_pkg::result_type result
);
   import tvc_pkg::*;

   logic [63:0] num_raw;
   logic [63:0] num_bits;

   assign num_raw = {boxed_word[2], boxed_word[1], ~boxed_word[1], boxed_word[63:3]};

   always_comb begin
      num_bits = num_raw;
      if (num_raw[62:0] == {EXP_START, ZERO_MANT}) begin
         num_bits = {num_raw[63], 63'd0};
      end else if (num_raw[62:52] == EXP_START) begin
         num_bits = {num_raw[63], EXP_ALL_ONES, num_raw[51:0]};
      end
   end

   always_comb begin
      result = '0;
      if (!boxed_word[0]) begin
         result.kind = KIND_NUM;
         result.value_out = num_bits;
      end else if (!boxed_word[1]) begin
         result.kind = KIND_INT;
         result.value_out = {{3{boxed_word[2]}}, boxed_word[63:3]};
      end else if (boxed_word == NONE_WORD) begin
         result.kind = KIND_NONE;
      end else if ((boxed_word[7:0] & TAG_MASK) == TAG_SHORT_STR) begin
         result.kind = KIND_SHORT_STR;
         result.length_out = boxed_word[6:4];
         result.value_out = {8'd0, boxed_word[63:8] & byte_mask(boxed_word[6:4])};
      end else if ((boxed_word[7:0] & TAG_MASK) == TAG_BOOL) begin
         result.kind = KIND_BOOL;
         result.value_out = {63'd0, &boxed_word[6:4]};
      end else begin
         result.value_out = {boxed_word[63:4], 4'd0};
         if (boxed_word[3:0] == TAG_LONG_STR) begin
            result.kind = KIND_LONG_STR;
         end else if (boxed_word[3:0] == TAG_ARRAY) begin
            result.kind = KIND_ARRAY;
         end else begin
            result.kind = KIND_OBJECT;
         end
      end
   end

endmodule

// File: hdl/tagged_value_codec.sv
// Channel  | Ports                                         | Handshake
// ---------+-----------------------------------------------+---------------------------
// request  | req_func, req_value_bits, req_text_length,    | start high, busy low
//          | req_boxed_word                                |
// response | rsp_boxed_out, rsp_kind, rsp_value_out,       | rsp_strobe, one cycle
//          | rsp_length_out, rsp_needs_heap                |
//
// One item per clock while reset is low; each item passes through the input register,
// the codec logic and the result register before its result is on the ports.
// busy is high only while reset is asserted; reset clears both valid flags.
// The receiver cannot stall: each result is shown for exactly one cycle.
module tagged_value_codec (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_func,
   input  logic [63:0] req_value_bits,
   input  logic [2:0]  req_text_length,
   input  logic [63:0] req_boxed_word,
   output logic        rsp_strobe,
   output logic [63:0] rsp_boxed_out,
   output logic [3:0]  rsp_kind,
   output logic [63:0] rsp_value_out,
   output logic [2:0]  rsp_length_out,
   output logic        rsp_needs_heap
);
   import tvc_pkg::*;

   logic        valid_ff;
   logic        valid_in;
   logic [2:0]  func_ff;
   logic [63:0] value_bits_ff;
   logic [2:0]  text_length_ff;
   logic [63:0] boxed_word_ff;
   logic        strobe_ff;
   result_type  result_ff;
   result_type  result_in;
   result_type  enc_result;
   result_type  dec_result;

   assign busy = reset;
   assign valid_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         strobe_ff <= valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (valid_in) begin
         func_ff <= req_func;
         value_bits_ff <= req_value_bits;
         text_length_ff <= req_text_length;
         boxed_word_ff <= req_boxed_word;
      end
      if (valid_ff) begin
         result_ff <= result_in;
      end
   end

   tvc_encode u_encode (
      .func        (func_ff),
      .value_bits  (value_bits_ff),
      .text_length (text_length_ff),
      .result      (enc_result)
   );

   tvc_decode u_decode (
      .boxed_word (boxed_word_ff),
      .result     (dec_result)
   );

   assign result_in = (func_ff == FUNC_DECODE) ? dec_result : enc_result;

   assign rsp_strobe = strobe_ff;
   assign rsp_boxed_out = result_ff.boxed_out;
   assign rsp_kind = result_ff.kind;
   assign rsp_value_out = result_ff.value_out;
   assign rsp_length_out = result_ff.length_out;
   assign rsp_needs_heap = result_ff.needs_heap;

   a_item_to_result: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> ##1 rsp_strobe)
      else $error("accepted item produced no result");

   a_heap_clears_word: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_needs_heap |-> rsp_boxed_out == '0)
      else $error("boxed word not cleared on heap fallback");

   a_heap_only_encode: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_needs_heap |-> rsp_kind == KIND_INVALID)
      else $error("heap flag on a decode result");

   a_length_short_only: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_kind != KIND_SHORT_STR |-> rsp_length_out == '0)
      else $error("length set on a non short string result");

endmodule
